[sv/ahbs_pkg.sv]
`timescale 1ns / 1ps

package ahbs_pkg;

    // Framing bytes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // At most four results come out of one input item
    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned SLOT_W      = $clog2(MAX_RESULTS);
    localparam int unsigned COUNT_W     = $clog2(MAX_RESULTS + 1);

    // Direction register values
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Register byte addresses
    localparam int unsigned     ADDR_W   = 3;
    localparam logic [ADDR_W-1:0] ADDR_DIRECTION = 3'd0;

    // One classified input item: the ordered results it produces
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [MAX_RESULTS-1:0]      valid;
        logic [MAX_RESULTS-1:0]      last;
        logic [COUNT_W-1:0]          count;
    } ahbs_burst_t;

    // Bytes sent escaped in encode
    function automatic logic needs_escape(input logic [7:0] b);
        return (b inside {[8'h00:8'h1F], ESC_BYTE, FLAG_BYTE});
    endfunction

    // Bytes that complete an escape in decode
    function automatic logic escape_partner(input logic [7:0] b);
        return (b inside {8'h5D, 8'h5E, [8'h20:8'h3F]});
    endfunction

endpackage

[sv/ahbs_front.sv]
`timescale 1ns / 1ps

module ahbs_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                direction,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                frame_end,
    output logic                push,
    output ahbs_pkg::ahbs_burst_t burst
);
    import ahbs_pkg::*;

    logic        inside_frame_reg;
    logic        inside_frame_next;
    logic        escape_pending_reg;
    logic        escape_pending_next;
    ahbs_burst_t burst_c;

    // Add one result at the next free slot
    function automatic ahbs_burst_t append(input ahbs_burst_t cur, input logic [7:0] val,
                                           input logic vld, input logic lst);
        ahbs_burst_t r;
        r = cur;
        r.bytes[cur.count[SLOT_W-1:0]] = val;
        r.valid[cur.count[SLOT_W-1:0]] = vld;
        r.last[cur.count[SLOT_W-1:0]]  = lst;
        r.count = cur.count + COUNT_W'(1);
        return r;
    endfunction

    // Classify the item and build its list of results
    always_comb
    begin
        logic handled;
        handled             = 1'b0;
        burst_c             = '0;
        inside_frame_next   = inside_frame_reg;
        escape_pending_next = escape_pending_reg;
        if (direction == DIR_ENCODE)
        begin
            if (!inside_frame_reg)
            begin
                burst_c           = append(burst_c, FLAG_BYTE, 1'b1, 1'b0);
                inside_frame_next = 1'b1;
            end
            if (needs_escape(data_byte))
            begin
                burst_c = append(burst_c, ESC_BYTE, 1'b1, 1'b0);
                burst_c = append(burst_c, data_byte ^ ESC_XOR, 1'b1, 1'b0);
            end
            else
            begin
                burst_c = append(burst_c, data_byte, 1'b1, 1'b0);
            end
            if (frame_end)
            begin
                burst_c           = append(burst_c, FLAG_BYTE, 1'b1, 1'b1);
                inside_frame_next = 1'b0;
            end
        end
        else
        begin
            if (escape_pending_reg)
            begin
                escape_pending_next = 1'b0;
                if (escape_partner(data_byte))
                begin
                    burst_c = append(burst_c, data_byte ^ ESC_XOR, 1'b1, 1'b0);
                    handled = 1'b1;
                end
                else
                begin
                    // bad partner: literal escape out, byte taken afresh
                    burst_c = append(burst_c, ESC_BYTE, 1'b1, 1'b0);
                end
            end
            if (!handled)
            begin
                if (data_byte == ESC_BYTE)
                    escape_pending_next = 1'b1;
                else if (data_byte != FLAG_BYTE)
                    burst_c = append(burst_c, data_byte, 1'b1, 1'b0);
            end
            if (frame_end)
            begin
                if (escape_pending_next)
                begin
                    burst_c             = append(burst_c, ESC_BYTE, 1'b1, 1'b0);
                    escape_pending_next = 1'b0;
                end
                burst_c = append(burst_c, 8'h00, 1'b0, 1'b1);
            end
        end
    end

    assign push  = accept && (burst_c.count != '0);
    assign burst = burst_c;

    // Frame and escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_frame_reg   <= 1'b0;
            escape_pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            inside_frame_reg   <= inside_frame_next;
            escape_pending_reg <= escape_pending_next;
        end
    end

    // A closing flag always ends the open frame
    a_enc_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && direction == DIR_ENCODE && frame_end) |=> !inside_frame_reg)
        else $error("encode frame still open after frame end");

    // No escape survives the end of a decoded frame
    a_dec_end_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && direction == DIR_DECODE && frame_end) |=> !escape_pending_reg)
        else $error("escape pending after frame end");

    // Encode always produces at least one byte
    a_enc_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && direction == DIR_ENCODE) |-> push)
        else $error("encode item produced no result");

endmodule

[sv/ahbs_queue.sv]
`timescale 1ns / 1ps

module ahbs_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ahbs_pkg::ahbs_burst_t push_data,
    input  logic                  pop,
    output logic                  full,
    output logic                  head_valid,
    output ahbs_pkg::ahbs_burst_t head
);
    import ahbs_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    ahbs_burst_t       entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

[sv/ahbs_back.sv]
`timescale 1ns / 1ps

module ahbs_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  ahbs_pkg::ahbs_burst_t head,
    output logic                  pop,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [7:0]            out_byte,
    output logic                  out_valid,
    output logic                  frame_last,
    output logic                  run_last
);
    import ahbs_pkg::*;

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              xfer;
    logic              at_end;

    // Present the current slot of the head burst
    assign res_valid  = head_valid;
    assign out_byte   = head.bytes[slot_reg];
    assign out_valid  = head.valid[slot_reg];
    assign frame_last = head.last[slot_reg];
    assign at_end     = ({1'b0, slot_reg} == (head.count - COUNT_W'(1)));
    assign run_last   = at_end;

    assign xfer = res_valid && res_ready;
    assign pop  = xfer && at_end;

    // Walk the slots, back to the first on pop
    always_comb
    begin
        slot_next = slot_reg;
        if (pop)
            slot_next = '0;
        else if (xfer)
            slot_next = slot_reg + SLOT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else
            slot_reg <= slot_next;
    end

    a_slot_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ({1'b0, slot_reg} < head.count))
        else $error("slot beyond burst length");

    a_idle_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (slot_reg == '0))
        else $error("slot not reset while queue empty");

    a_burst_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head.count != '0))
        else $error("empty burst in queue");

endmodule

[sv/async_hdlc_byte_stuffing.sv]
`timescale 1ns / 1ps

// Byte-stuffing framer/deframer for asynchronous HDLC-style links. The direction
// register (byte address 0, bit 0) picks encode (0: opening/closing 0x7E flags,
// control bytes and 0x7D/0x7E escaped) or decode (1: flags dropped, escapes undone,
// an end marker with out_valid low at each frame end). Each input transfer yields
// zero to four result transfers; run_last marks the last one of an item. The front
// classifies one item per cycle into a queue of QUEUE_DEPTH entries; the back sends
// one result per cycle while res_ready is high. An item that yields one result
// therefore sustains one item per cycle; one with more results holds the output for
// each of them, and input stalls only once the queue is full.
// State is kept across direction changes; write the register only while idle.

module async_hdlc_byte_stuffing
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ahbs_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          frame_end,
    // result channel
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [7:0]                    out_byte,
    output logic                          out_valid,
    output logic                          frame_last,
    output logic                          run_last
);
    import ahbs_pkg::*;

    logic        direction_reg;
    logic        cfg_write;
    logic        in_xfer;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        head_valid;
    ahbs_burst_t burst;
    ahbs_burst_t head;

    // Register port; low address bits ignored
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[ADDR_W-1] == ADDR_DIRECTION[ADDR_W-1]);
    assign prdata    = (paddr[ADDR_W-1] == ADDR_DIRECTION[ADDR_W-1]) ?
                       {31'd0, direction_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            direction_reg <= DIR_ENCODE;
        else if (cfg_write)
            direction_reg <= pwdata[0];
    end

    assign in_ready = !q_full;
    assign in_xfer  = in_valid && in_ready;

    ahbs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .direction (direction_reg),
        .accept    (in_xfer),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .push      (push),
        .burst     (burst)
    );

    ahbs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (burst),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    ahbs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_byte   (out_byte),
        .out_valid  (out_valid),
        .frame_last (frame_last),
        .run_last   (run_last)
    );

endmodule
